### rtl/crrm_pkg.sv
// Shared types and constants for the control-record relay mapper.
// No dependencies; used by the parser, result queue, top level and checker.
`default_nettype none

package crrm_pkg;

  localparam int MAP_ENTRIES_DEF = 32;
  localparam int RELAY_COUNT_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 6;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    RK_ENTRY = 2'd0,
    RK_OK    = 2'd1,
    RK_BAD   = 2'd2
  } rkind_t;

  typedef struct packed {
    logic [7:0]  node_addr;
    logic        split;
    logic [15:0] rec_count;
  } cfg_t;

  typedef struct packed {
    rkind_t            kind;
    logic [7:0]        circuit;
    logic [4:0]        relay;
    logic [9:0]        level;
    logic [CNT_W-1:0]  count;
    logic              last;
  } res_t;

  // results raised by one byte, entry first
  typedef struct packed {
    logic ent_vld;
    logic sts_vld;
    res_t ent;
    res_t sts;
  } push_t;

endpackage

`default_nettype wire

### rtl/control_record_relay_mapper.sv
// Top level of the control-record relay mapper: config registers, input
// register, parser and result queue. Depends on crrm_pkg, crrm_parser, crrm_outq.
//
// Usage:
//  - Input channel (in_valid/in_ready): one section byte per request, with
//    in_last_byte high on the final byte of the section.
//  - Result channel (out_valid/out_ready): mapping entries (kind 0) as their
//    fifth byte is parsed, then one status (kind 1 ok, kind 2 malformed) with
//    out_last_result high after the last byte of the section.
//  - Config port: cfg_wr_en/cfg_index/cfg_wdata; the user must write it only
//    while the block is idle (not enforced by the block). record_count is
//    sampled at a section's first byte.
//  - Path: each byte is held in the input register, then parsed into the
//    result queue, from which its results are offered.
//  - Throughput: one byte per cycle while the result queue has room; a closing
//    byte that also completes an entry gives two results, drained one per cycle.
//  - Stall: the four-deep result queue absorbs a stalled receiver; bytes stop
//    being taken once fewer than two queue slots are free.
//  - Reset (rst_n low, synchronous): registers return to node 0, direct
//    mapping, one record; section state and the queue are emptied.
`default_nettype none

module control_record_relay_mapper #(
  parameter int MAP_ENTRIES = crrm_pkg::MAP_ENTRIES_DEF,
  parameter int RELAY_COUNT = crrm_pkg::RELAY_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_last_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_result_kind,
  output logic [7:0]                          out_circuit,
  output logic [4:0]                          out_relay,
  output logic [9:0]                          out_level,
  output logic [5:0]                          out_entry_count,
  output logic                                out_last_result,
  input  wire logic                           cfg_wr_en,
  input  wire logic [crrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  crrm_pkg::cfg_t  cfg_r;
  logic            s1_vld_r;
  logic [7:0]      s1_data_r;
  logic            s1_last_r;
  logic            s1_go, q_room;
  crrm_pkg::push_t push;
  crrm_pkg::res_t  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_addr <= 8'd0;
      cfg_r.split     <= 1'b0;
      cfg_r.rec_count <= 16'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        crrm_pkg::CFG_NODE_ADDR:  cfg_r.node_addr <= cfg_wdata[7:0];
        crrm_pkg::CFG_SPLIT_MODE: cfg_r.split     <= cfg_wdata[0];
        crrm_pkg::CFG_REC_COUNT:  cfg_r.rec_count <= cfg_wdata[15:0];
        default:                  cfg_r           <= cfg_r;
      endcase
    end
  end

  assign s1_go    = s1_vld_r && q_room;
  assign in_ready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  crrm_parser #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .RELAY_COUNT (RELAY_COUNT)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (s1_go),
    .data  (s1_data_r),
    .last  (s1_last_r),
    .push  (push)
  );

  crrm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_ready),
    .head_vld  (out_valid),
    .head      (head),
    .room      (q_room)
  );

  assign out_result_kind = head.kind;
  assign out_circuit     = head.circuit;
  assign out_relay       = head.relay;
  assign out_level       = head.level;
  assign out_entry_count = head.count;
  assign out_last_result = head.last;

endmodule

`default_nettype wire

### rtl/crrm_parser.sv
// Byte-serial record parser: section state, entry decode and relay mapping.
// Depends on crrm_pkg.
`default_nettype none

module crrm_parser #(
  parameter int MAP_ENTRIES = crrm_pkg::MAP_ENTRIES_DEF,
  parameter int RELAY_COUNT = crrm_pkg::RELAY_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire crrm_pkg::cfg_t cfg,
  input  wire logic          step,
  input  wire logic [7:0]    data,
  input  wire logic          last,
  output crrm_pkg::push_t    push
);

  localparam int CNT_IW = $clog2(MAP_ENTRIES + 1);

  typedef enum logic [10:0] {
    PH_START   = 11'b000_0000_0001,
    PH_CIRC    = 11'b000_0000_0010,
    PH_HDR     = 11'b000_0000_0100,
    PH_NAMELEN = 11'b000_0000_1000,
    PH_NAME    = 11'b000_0001_0000,
    PH_CMDLEN  = 11'b000_0010_0000,
    PH_CMD     = 11'b000_0100_0000,
    PH_OUTLEN  = 11'b000_1000_0000,
    PH_OUTCNT  = 11'b001_0000_0000,
    PH_ENTRY   = 11'b010_0000_0000,
    PH_BLKSKIP = 11'b100_0000_0000
  } phase_t;

  phase_t             phase_r, phase_nxt, ph_cur;
  logic [2:0]         idx_r, idx_nxt;
  logic [7:0]         circ_r, circ_nxt;
  logic [31:0]        skip_r, skip_nxt;
  logic [31:0]        olen_r, olen_nxt;
  logic [15:0]        oleft_r, oleft_nxt;
  logic [15:0]        rleft_r, rleft_nxt, rl_cur;
  logic [15:0]        addr_r, addr_nxt;
  logic [9:0]         level_r, level_nxt;
  logic [CNT_IW-1:0]  emitted_r, emitted_nxt, sts_cnt;
  logic               err_r, err_nxt;

  logic [31:0]        skip_dec, byte_sh, skip_ins, olen_ins;
  logic [15:0]        cnt_full;
  logic               blk_match;
  logic [7:0]         ch;
  logic [4:0]         relay_map;
  logic               ent_fire, ok;

  // relay lookup on the completed channel address
  always_comb begin
    relay_map = '0;
    ch        = addr_r[7:0];
    if (addr_r[15:8] == cfg.node_addr) begin
      if (cfg.split) begin
        if (ch inside {[8'd12:8'd15]}) begin
          relay_map = 5'(ch - 8'd11);
        end else if (ch < 8'd4) begin
          relay_map = 5'(ch + 8'd5);
        end
      end else if (ch < 8'(RELAY_COUNT)) begin
        relay_map = 5'(ch + 8'd1);
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    circ_nxt    = circ_r;
    skip_nxt    = skip_r;
    olen_nxt    = olen_r;
    oleft_nxt   = oleft_r;
    rleft_nxt   = rleft_r;
    addr_nxt    = addr_r;
    level_nxt   = level_r;
    emitted_nxt = emitted_r;
    err_nxt     = err_r;
    ent_fire    = 1'b0;
    ok          = 1'b0;
    sts_cnt     = '0;

    ph_cur   = phase_r;
    rl_cur   = rleft_r;
    skip_dec = skip_r - 32'd1;
    byte_sh  = {24'b0, data} << {idx_r[1:0], 3'b000};
    skip_ins = (idx_r == 3'd0) ? {24'b0, data} : (skip_r | byte_sh);
    olen_ins = (idx_r == 3'd0) ? {24'b0, data} : (olen_r | byte_sh);
    cnt_full = {data, oleft_r[7:0]};
    blk_match = olen_r == (32'({cnt_full, 2'b00}) + 32'(cnt_full) + 32'd2);

    if (step && !err_r) begin
      if (phase_r == PH_START) begin
        ph_cur = PH_CIRC;
        rl_cur = cfg.rec_count;
      end
      phase_nxt = ph_cur;
      rleft_nxt = rl_cur;
      case (ph_cur)
        PH_CIRC: begin
          if (rl_cur == 16'd0) begin
            err_nxt = 1'b1;
          end else begin
            circ_nxt  = data;
            idx_nxt   = 3'd0;
            phase_nxt = PH_HDR;
          end
        end
        PH_HDR: begin
          if (idx_r == 3'd5) begin
            idx_nxt   = 3'd0;
            phase_nxt = PH_NAMELEN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_NAMELEN: begin
          skip_nxt  = {24'b0, data};
          idx_nxt   = 3'd0;
          phase_nxt = (data != 8'd0) ? PH_NAME : PH_CMDLEN;
        end
        PH_NAME, PH_CMD: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            idx_nxt   = 3'd0;
            phase_nxt = (ph_cur == PH_NAME) ? PH_CMDLEN : PH_OUTLEN;
          end
        end
        PH_CMDLEN: begin
          skip_nxt = skip_ins;
          if (idx_r == 3'd3) begin
            idx_nxt   = 3'd0;
            phase_nxt = (skip_ins != 32'd0) ? PH_CMD : PH_OUTLEN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_OUTLEN: begin
          olen_nxt = olen_ins;
          if (idx_r == 3'd3) begin
            idx_nxt = 3'd0;
            if (olen_ins < 32'd2) begin
              err_nxt = 1'b1;
            end else begin
              skip_nxt  = olen_ins;
              phase_nxt = PH_OUTCNT;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_OUTCNT: begin
          skip_nxt = skip_dec;
          if (idx_r == 3'd0) begin
            oleft_nxt = {8'b0, data};
            idx_nxt   = 3'd1;
          end else begin
            // a count that disagrees with the block length voids the entries
            oleft_nxt = blk_match ? cnt_full : 16'd0;
            idx_nxt   = 3'd0;
            if (skip_dec == 32'd0) begin
              rleft_nxt = rl_cur - 16'd1;
              phase_nxt = PH_CIRC;
            end else begin
              phase_nxt = (blk_match && cnt_full != 16'd0) ? PH_ENTRY : PH_BLKSKIP;
            end
          end
        end
        PH_ENTRY: begin
          skip_nxt = skip_dec;
          case (idx_r)
            3'd0:    addr_nxt  = {8'b0, data};
            3'd1:    addr_nxt  = {data, addr_r[7:0]};
            3'd2:    level_nxt = {2'b0, data};
            3'd3:    level_nxt = {data[1:0], level_r[7:0]};
            default: level_nxt = level_r;
          endcase
          if (idx_r == 3'd4) begin
            idx_nxt   = 3'd0;
            oleft_nxt = oleft_r - 16'd1;
            if (relay_map != 5'd0 && emitted_r < CNT_IW'(MAP_ENTRIES)) begin
              ent_fire    = 1'b1;
              emitted_nxt = emitted_r + CNT_IW'(1);
            end
            if (skip_dec == 32'd0) begin
              rleft_nxt = rl_cur - 16'd1;
              phase_nxt = PH_CIRC;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_BLKSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            rleft_nxt = rl_cur - 16'd1;
            idx_nxt   = 3'd0;
            phase_nxt = PH_CIRC;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end

    if (step && last) begin
      ok      = !err_nxt && phase_nxt == PH_CIRC && rleft_nxt == 16'd0;
      sts_cnt = emitted_nxt;
      // section closes: back to the start state
      phase_nxt   = PH_START;
      idx_nxt     = 3'd0;
      circ_nxt    = 8'd0;
      skip_nxt    = 32'd0;
      olen_nxt    = 32'd0;
      oleft_nxt   = 16'd0;
      rleft_nxt   = 16'd0;
      addr_nxt    = 16'd0;
      level_nxt   = 10'd0;
      emitted_nxt = '0;
      err_nxt     = 1'b0;
    end
  end

  always_comb begin
    push.ent_vld     = ent_fire;
    push.ent.kind    = crrm_pkg::RK_ENTRY;
    push.ent.circuit = circ_r;
    push.ent.relay   = relay_map;
    push.ent.level   = level_r;
    push.ent.count   = crrm_pkg::CNT_W'(emitted_r + CNT_IW'(1));
    push.ent.last    = 1'b0;

    push.sts_vld     = step && last;
    push.sts.kind    = ok ? crrm_pkg::RK_OK : crrm_pkg::RK_BAD;
    push.sts.circuit = 8'd0;
    push.sts.relay   = 5'd0;
    push.sts.level   = 10'd0;
    push.sts.count   = crrm_pkg::CNT_W'(sts_cnt);
    push.sts.last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      idx_r     <= 3'd0;
      circ_r    <= 8'd0;
      skip_r    <= 32'd0;
      olen_r    <= 32'd0;
      oleft_r   <= 16'd0;
      rleft_r   <= 16'd0;
      addr_r    <= 16'd0;
      level_r   <= 10'd0;
      emitted_r <= '0;
      err_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      circ_r    <= circ_nxt;
      skip_r    <= skip_nxt;
      olen_r    <= olen_nxt;
      oleft_r   <= oleft_nxt;
      rleft_r   <= rleft_nxt;
      addr_r    <= addr_nxt;
      level_r   <= level_nxt;
      emitted_r <= emitted_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crrm_outq.sv
// Four-deep result queue; takes up to two results a cycle, hands out one.
// Depends on crrm_pkg.
`default_nettype none

module crrm_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire crrm_pkg::push_t push,
  input  wire logic            pop_ready,
  output logic                 head_vld,
  output crrm_pkg::res_t       head,
  output logic                 room
);

  crrm_pkg::res_t                mem_r [crrm_pkg::Q_DEPTH];
  logic [crrm_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_second;
  logic [crrm_pkg::Q_CW-1:0]     count_r, count_nxt, n_push;
  logic                          pop;

  assign head_vld  = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign room      = count_r <= crrm_pkg::Q_CW'(crrm_pkg::Q_DEPTH - 2);
  assign pop       = head_vld && pop_ready;
  assign wr_second = wr_ptr_r + crrm_pkg::Q_AW'(push.ent_vld);
  assign n_push    = crrm_pkg::Q_CW'(push.ent_vld) + crrm_pkg::Q_CW'(push.sts_vld);
  assign count_nxt = count_r + n_push - crrm_pkg::Q_CW'(pop);
  assign wr_ptr_nxt = wr_ptr_r + crrm_pkg::Q_AW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + crrm_pkg::Q_AW'(pop);

  always_ff @(posedge clk) begin
    if (push.ent_vld) begin
      mem_r[wr_ptr_r] <= push.ent;
    end
    if (push.sts_vld) begin
      mem_r[wr_second] <= push.sts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crrm_checker.sv
// Port-level checks for control_record_relay_mapper, bound to the top level.
// Depends on crrm_pkg.
`default_nettype none

module crrm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_result_kind,
  input wire logic [7:0] out_circuit,
  input wire logic [4:0] out_relay,
  input wire logic [9:0] out_level,
  input wire logic [5:0] out_entry_count,
  input wire logic       out_last_result
);

  // an entry always names a real relay and never closes the section
  a_entry_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == crrm_pkg::RK_ENTRY
    |-> !out_last_result && out_relay != 5'd0 && out_relay <= 5'd16
        && out_entry_count != 6'd0)
    else $error("entry request malformed");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != crrm_pkg::RK_ENTRY
    |-> out_last_result && out_relay == 5'd0 && out_circuit == 8'd0
        && out_level == 10'd0)
    else $error("status request carries entry fields");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind == crrm_pkg::RK_ENTRY
                  || out_result_kind == crrm_pkg::RK_OK
                  || out_result_kind == crrm_pkg::RK_BAD)
    else $error("undefined result kind");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
    |=> out_valid && $stable(out_result_kind) && $stable(out_relay)
        && $stable(out_entry_count) && $stable(out_last_result))
    else $error("stalled result request changed");

endmodule

bind control_record_relay_mapper crrm_checker u_chk (.*);

`default_nettype wire

### verif/control_record_relay_mapper_tb.sv
// Self-checking testbench for control_record_relay_mapper: byte-serial sections
// are pushed in; each result must match a local parser model or a typed row.
// Depends on crrm_pkg and the control_record_relay_mapper RTL.
module control_record_relay_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_GAP   = 6;
  localparam int PHASE_BYTES = 570;
  localparam int CFG_SPAN    = 4;   // sections per register setting

  typedef enum logic [3:0] {
    SEC_START, REC_CIRC, REC_HDR, REC_NAMELEN, REC_NAME, REC_CMDLEN,
    REC_CMD, REC_OUTLEN, REC_OUTCNT, REC_ENTRY, REC_BLKSKIP
  } parse_phase_t;

  typedef enum int {
    SK_GOOD, SK_TRUNC, SK_LEFTOVER, SK_SHORT_BLK, SK_LEN_MISMATCH, SK_NOISE,
    SK_FLOOD, SK_COUNT
  } sec_kind_t;

  typedef enum int {RF_FULL, RF_SHORT_BLK, RF_BAD_LEN} rec_form_t;

  typedef struct {
    logic [7:0]     data;
    logic           last;
    int             n_typed;  // -1: results come from the parser model
    crrm_pkg::res_t r0;
    crrm_pkg::res_t r1;
  } dir_row_t;

  localparam crrm_pkg::res_t NIL       = '0;
  localparam crrm_pkg::res_t BAD_EMPTY = '{kind: crrm_pkg::RK_BAD, circuit: 8'd0,
                                           relay: 5'd0, level: 10'd0, count: 6'd0,
                                           last: 1'b1};
  localparam crrm_pkg::res_t ENT_DIR   = '{kind: crrm_pkg::RK_ENTRY, circuit: 8'h5A,
                                           relay: 5'd8, level: 10'h3FF, count: 6'd1,
                                           last: 1'b0};
  localparam crrm_pkg::res_t OK_ONE    = '{kind: crrm_pkg::RK_OK, circuit: 8'd0,
                                           relay: 5'd0, level: 10'd0, count: 6'd1,
                                           last: 1'b1};

  // lone byte after reset, then one record whose closing byte ends an entry
  dir_row_t dir_tab [24] = '{
    '{8'hFF, 1'b1,  1, BAD_EMPTY, NIL},
    '{8'h5A, 1'b0, -1, NIL, NIL},
    '{8'hFF, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'hFF, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'hFF, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h00, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h00, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h07, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h00, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h01, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'h07, 1'b0, -1, NIL, NIL}, '{8'h00, 1'b0, -1, NIL, NIL},
    '{8'hFF, 1'b0, -1, NIL, NIL}, '{8'hFF, 1'b0, -1, NIL, NIL},
    '{8'hFF, 1'b1,  2, ENT_DIR, OK_ONE}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_circuit;
  logic [4:0]  out_relay;
  logic [9:0]  out_level;
  logic [5:0]  out_entry_count;
  logic        out_last_result;
  logic        cfg_wr_en = 1'b0;
  logic [crrm_pkg::CFG_IDX_W-1:0]  cfg_index = crrm_pkg::CFG_NODE_ADDR;
  logic [crrm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  control_record_relay_mapper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_circuit     (out_circuit),
    .out_relay       (out_relay),
    .out_level       (out_level),
    .out_entry_count (out_entry_count),
    .out_last_result (out_last_result),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // register copies and parser state of the model
  logic [7:0]   p_node;
  logic         p_split;
  logic [15:0]  p_recs;
  parse_phase_t ph;
  logic [2:0]   fidx;
  logic [7:0]   circ;
  logic [31:0]  skip_left;
  logic [31:0]  blk_len;
  logic [15:0]  ents_left;
  logic [15:0]  recs_left;
  logic [15:0]  chan_addr;
  logic [23:0]  pk_word;
  logic [5:0]   n_emitted;
  logic         err;

  crrm_pkg::res_t pending_q[$];
  logic [7:0]     sec_bytes[$];
  crrm_pkg::res_t head;
  int             errors = 0;
  int             live_bytes = 0;
  int             snd_idle_pct = 0;
  int             rcv_idle_pct = 0;

  function automatic void clear_section();
    ph        = SEC_START;
    fidx      = '0;
    circ      = '0;
    skip_left = '0;
    blk_len   = '0;
    ents_left = '0;
    recs_left = '0;
    chan_addr = '0;
    pk_word   = '0;
    n_emitted = '0;
    err       = 1'b0;
  endfunction

  function automatic logic [4:0] relay_for(logic [15:0] addr);
    logic [7:0] ch;
    ch = addr[7:0];
    if (addr[15:8] != p_node) return 5'd0;
    if (p_split) begin
      if (ch >= 8'd12 && ch < 8'd16) return 5'(ch - 8'd11);
      if (ch < 8'd4) return 5'(ch + 8'd5);
      return 5'd0;
    end
    if (ch < 8'(crrm_pkg::RELAY_COUNT_DEF)) return 5'(ch + 8'd1);
    return 5'd0;
  endfunction

  function automatic void record_done();
    recs_left = recs_left - 16'd1;
    ph        = REC_CIRC;
    fidx      = '0;
  endfunction

  // advance the parser by one byte; keep=0 updates state but drops results
  function automatic void parse_byte(logic [7:0] b, logic last, bit keep);
    logic [4:0] rly;
    logic       ok;
    if (!err) begin
      if (ph == SEC_START) begin
        recs_left = p_recs;
        ph        = REC_CIRC;
      end
      case (ph)
        REC_CIRC: begin
          if (recs_left == 0) begin
            err = 1'b1;
          end else begin
            circ = b;
            fidx = '0;
            ph   = REC_HDR;
          end
        end
        REC_HDR: begin
          fidx++;
          if (fidx >= 3'd6) begin
            fidx = '0;
            ph   = REC_NAMELEN;
          end
        end
        REC_NAMELEN: begin
          skip_left = 32'(b);
          fidx      = '0;
          ph        = (b != 0) ? REC_NAME : REC_CMDLEN;
        end
        REC_NAME, REC_CMD: begin
          skip_left--;
          if (skip_left == 0) begin
            fidx = '0;
            ph   = (ph == REC_NAME) ? REC_CMDLEN : REC_OUTLEN;
          end
        end
        REC_CMDLEN: begin
          if (fidx == 0) skip_left = 32'(b);
          else skip_left |= 32'(b) << (8 * fidx[1:0]);
          fidx++;
          if (fidx >= 3'd4) begin
            fidx = '0;
            ph   = (skip_left != 0) ? REC_CMD : REC_OUTLEN;
          end
        end
        REC_OUTLEN: begin
          if (fidx == 0) blk_len = 32'(b);
          else blk_len |= 32'(b) << (8 * fidx[1:0]);
          fidx++;
          if (fidx >= 3'd4) begin
            fidx = '0;
            if (blk_len < 32'd2) begin
              err = 1'b1;
            end else begin
              skip_left = blk_len;
              ph        = REC_OUTCNT;
            end
          end
        end
        REC_OUTCNT: begin
          skip_left--;
          if (fidx == 0) begin
            ents_left = 16'(b);
            fidx      = 3'd1;
          end else begin
            ents_left[15:8] = b;
            fidx = '0;
            // a block whose length disagrees with its count is skipped whole
            if (blk_len != 32'd2 + 32'd5 * 32'(ents_left)) ents_left = '0;
            if (skip_left == 0) record_done();
            else ph = (ents_left != 0) ? REC_ENTRY : REC_BLKSKIP;
          end
        end
        REC_ENTRY: begin
          skip_left--;
          case (fidx)
            3'd0: chan_addr = 16'(b);
            3'd1: chan_addr[15:8] = b;
            3'd2: pk_word = 24'(b);
            default: pk_word |= 24'(b) << (8 * (fidx - 3'd2));
          endcase
          fidx++;
          if (fidx >= 3'd5) begin
            rly       = relay_for(chan_addr);
            fidx      = '0;
            ents_left = ents_left - 16'd1;
            if (rly != 0 && n_emitted < crrm_pkg::MAP_ENTRIES_DEF) begin
              n_emitted++;
              if (keep)
                pending_q.push_back('{kind: crrm_pkg::RK_ENTRY, circuit: circ,
                                      relay: rly, level: pk_word[9:0],
                                      count: n_emitted, last: 1'b0});
            end
            if (skip_left == 0) record_done();
          end
        end
        REC_BLKSKIP: begin
          skip_left--;
          if (skip_left == 0) record_done();
        end
        default: err = 1'b1;
      endcase
    end
    if (last) begin
      ok = !err && ph == REC_CIRC && recs_left == 0;
      if (keep)
        pending_q.push_back('{kind: ok ? crrm_pkg::RK_OK : crrm_pkg::RK_BAD,
                              circuit: 8'd0, relay: 5'd0, level: 10'd0,
                              count: n_emitted, last: 1'b1});
      clear_section();
    end
  endfunction

  function automatic void push_u32(logic [31:0] v);
    for (int i = 0; i < 4; i++) sec_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_record(rec_form_t form, int n_ent, bit all_hit);
    int          nm_len;
    int          cmd_len;
    int          len;
    logic [15:0] cnt;
    logic [7:0]  ch;
    logic [7:0]  hi;
    sec_bytes.push_back(8'($urandom));
    repeat (6) sec_bytes.push_back(8'($urandom));
    nm_len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(3);
    sec_bytes.push_back(8'(nm_len));
    repeat (nm_len) sec_bytes.push_back(8'($urandom));
    cmd_len = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(3);
    push_u32(32'(cmd_len));
    repeat (cmd_len) sec_bytes.push_back(8'($urandom));
    case (form)
      RF_SHORT_BLK: push_u32(32'($urandom_range(1)));
      RF_BAD_LEN: begin
        len = $urandom_range(2, 30);
        cnt = $urandom_range(1) ? 16'($urandom_range(6)) : 16'($urandom);
        push_u32(32'(len));
        sec_bytes.push_back(cnt[7:0]);
        sec_bytes.push_back(cnt[15:8]);
        repeat (len - 2) sec_bytes.push_back(8'($urandom));
      end
      default: begin
        push_u32(32'(2 + 5 * n_ent));
        sec_bytes.push_back(8'(n_ent));
        sec_bytes.push_back(8'(n_ent >> 8));
        repeat (n_ent) begin
          if (all_hit) ch = 8'($urandom_range(3));
          else ch = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
          hi = (all_hit || $urandom_range(4) != 0) ? p_node : 8'($urandom);
          sec_bytes.push_back(ch);
          sec_bytes.push_back(hi);
          repeat (3) sec_bytes.push_back(8'($urandom));
        end
      end
    endcase
  endfunction

  function automatic void build_section(sec_kind_t k);
    int        recs;
    int        keep_n;
    rec_form_t form;
    sec_bytes.delete();
    recs = (p_recs > 16'd3) ? 3 : int'(p_recs);
    if (k == SK_NOISE) begin
      repeat ($urandom_range(1, 12)) sec_bytes.push_back(8'($urandom));
    end else begin
      for (int r = 0; r < recs; r++) begin
        form = RF_FULL;
        if (k == SK_SHORT_BLK && r == recs - 1) form = RF_SHORT_BLK;
        if (k == SK_LEN_MISMATCH && r == 0) form = RF_BAD_LEN;
        add_record(form, (k == SK_FLOOD && r == 0) ? $urandom_range(33, 36)
                                                    : $urandom_range(4),
                   k == SK_FLOOD);
      end
      // bytes past the end, or past an error, which must be ignored
      if (k == SK_LEFTOVER || k == SK_SHORT_BLK)
        repeat ($urandom_range(1, 4)) sec_bytes.push_back(8'($urandom));
      if (k == SK_TRUNC && sec_bytes.size() > 1) begin
        keep_n = $urandom_range(1, sec_bytes.size() - 1);
        while (sec_bytes.size() > keep_n) void'(sec_bytes.pop_back());
      end
    end
    if (sec_bytes.size() == 0) sec_bytes.push_back(8'($urandom));
  endfunction

  function automatic sec_kind_t pick_kind();
    int w;
    w = $urandom_range(99);
    if (w < 57) return SK_GOOD;
    if (w < 65) return SK_TRUNC;
    if (w < 72) return SK_LEFTOVER;
    if (w < 79) return SK_SHORT_BLK;
    if (w < 89) return SK_LEN_MISMATCH;
    if (w < 97) return SK_NOISE;
    return SK_FLOOD;
  endfunction

  task automatic send_byte(logic [7:0] d, logic last, bit keep);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    if (!err) live_bytes++;
    parse_byte(d, last, keep);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // extremes come round every ten settings, random ones in between
  task automatic apply_config(int k);
    logic [7:0]  node;
    logic        split;
    logic [15:0] rc;
    node  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                     : 8'($urandom);
    split = 1'($urandom);
    rc    = 16'($urandom_range(1, 3));
    case (k % 10)
      0: begin node = 8'h00; split = 1'b0; rc = 16'd1; end
      1: begin node = 8'hFF; split = 1'b1; rc = 16'd3; end
      2: begin split = 1'b0; rc = 16'hFFFF; end
      3: begin split = 1'b1; rc = 16'd0; end
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= crrm_pkg::CFG_NODE_ADDR;
    cfg_wdata <= {8'($urandom), node};
    @(posedge clk);
    cfg_index <= crrm_pkg::CFG_SPLIT_MODE;
    cfg_wdata <= {15'($urandom), split};
    @(posedge clk);
    cfg_index <= crrm_pkg::CFG_REC_COUNT;
    cfg_wdata <= rc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_node  = node;
    p_split = split;
    p_recs  = rc;
  endtask

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result_kind: expected none, got %0d", out_result_kind);
        errors++;
      end else begin
        head = pending_q.pop_front();
        cmp_field("result_kind", 16'(head.kind), 16'(out_result_kind));
        cmp_field("circuit", 16'(head.circuit), 16'(out_circuit));
        cmp_field("relay", 16'(head.relay), 16'(out_relay));
        cmp_field("level", 16'(head.level), 16'(out_level));
        cmp_field("entry_count", 16'(head.count), 16'(out_entry_count));
        cmp_field("last_result", 16'(head.last), 16'(out_last_result));
      end
    end
  end

  initial begin
    int start;
    int n_sec;
    int n_cfg;
    sec_kind_t k;
    n_sec = 0;
    n_cfg = 0;
    p_node  = 8'd0;
    p_split = 1'b0;
    p_recs  = 16'd1;
    clear_section();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 15;
    rcv_idle_pct = 66;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].n_typed > 0) pending_q.push_back(dir_tab[i].r0);
      if (dir_tab[i].n_typed > 1) pending_q.push_back(dir_tab[i].r1);
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].n_typed < 0);
    end
    for (int m = 0; m < 3; m++) begin
      snd_idle_pct = (m == 0) ? 15 : (m == 1) ? 66 : 0;
      rcv_idle_pct = (m == 0) ? 66 : (m == 1) ? 15 : 0;
      start = live_bytes;
      for (int s = 0; live_bytes - start < PHASE_BYTES; s++) begin
        // settle the block before touching the registers
        if (s % CFG_SPAN == 0) begin
          drain();
          apply_config(n_cfg);
          n_cfg++;
        end
        k = (n_sec < SK_COUNT) ? sec_kind_t'(n_sec) : pick_kind();
        n_sec++;
        build_section(k);
        foreach (sec_bytes[i]) send_byte(sec_bytes[i], i == sec_bytes.size() - 1, 1'b1);
      end
    end
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
